>>> design/sle_pkg.sv
// Shared types, constants and the pattern row address function for sprite line evaluation.
package sle_pkg;

   // Default sizes for the top level parameters
   localparam int ENTRY_COUNT_DEFAULT = 64;
   localparam int LINE_SLOTS_DEFAULT  = 8;

   // Store row layout: four bytes per sprite entry
   localparam int LANE_COUNT = 4;
   localparam int LANE_BITS  = 8;
   localparam int ROW_BITS   = LANE_COUNT * LANE_BITS;

   // Command codes of the request word
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // Configuration register indexes
   localparam int               CSR_INDEX_W   = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TALL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SEL = 2'd1;

   typedef struct packed {
      logic       command;
      logic [7:0] store_address;
      logic [7:0] store_data;
      logic [7:0] line_number;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [2:0]  slot_index;
      logic [12:0] plane_address;
      logic [7:0]  horizontal_pos;
      logic [1:0]  palette_choice;
      logic        behind_background;
      logic        mirror_horizontal;
      logic        zero_on_line;
      logic        overflow_flag;
      logic        last_result;
   } rsp_type;

   // Per-sprite data held between the scan and the result output
   typedef struct packed {
      logic [12:0] plane_address;
      logic [7:0]  horizontal_pos;
      logic [1:0]  palette_choice;
      logic        behind_background;
      logic        mirror_horizontal;
   } slot_type;

   // Low bit plane row address for one sprite, offset being the row within the sprite
   function automatic logic [12:0] plane_row_address(
      input logic       tall,
      input logic       table_sel,
      input logic [7:0] tile,
      input logic [7:0] attr,
      input logic [3:0] offset
   );
      logic       vflip;
      logic [2:0] row;
      logic       top;
      logic       half;
      vflip = attr[7];
      row   = vflip ? ~offset[2:0] : offset[2:0];
      top   = ~offset[3];
      // bottom tile of the pair unless top half and flip disagree
      half  = ~(top ^ vflip);
      if (tall) begin
         return {tile[0], tile[7:1], half, 1'b0, row};
      end else begin
         return {table_sel, tile, 1'b0, row};
      end
   endfunction

endpackage

>>> design/sle_store.sv
// Sprite attribute store: one row per entry, byte lane writes, registered read.
module sle_store #(
   parameter int ENTRY_COUNT = sle_pkg::ENTRY_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(ENTRY_COUNT)-1:0]      wr_index,
   input  logic [sle_pkg::LANE_COUNT-1:0]      wr_lanes,
   input  logic [sle_pkg::ROW_BITS-1:0]        wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(ENTRY_COUNT)-1:0]      rd_index,
   output logic [sle_pkg::ROW_BITS-1:0]        rd_data
);
   import sle_pkg::*;

   logic [ROW_BITS-1:0] mem [ENTRY_COUNT];
   logic [ROW_BITS-1:0] rd_data_ff;

   // Write the enabled byte lanes of one row
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < LANE_COUNT; i++) begin
            if (wr_lanes[i]) begin
               mem[wr_index][i*LANE_BITS +: LANE_BITS] <= wr_data[i*LANE_BITS +: LANE_BITS];
            end
         end
      end
   end

   // Read one row, data valid the next cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_index];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sprite_line_evaluation.sv
// Top level of sprite line evaluation: sequencer, slot buffer and result register.
//
// Usage:
//  - Request channel (req_valid / req_stall / req_data) takes one word per item.
//    A write word stores one byte of the sprite attribute store (entry*4 + field)
//    and gives no result.
//  - An evaluate word scans all ENTRY_COUNT entries, one store row per cycle from
//    the store's read port, then sends one result word per kept sprite (at most
//    LINE_SLOTS), or one word with found = 0 when no sprite is on the line.
//    req_stall is high for the whole scan and while the result words are sent.
//  - Result channel (rsp_valid / rsp_stall / rsp_data) is driven from an output
//    register. While the receiver stalls, the word holds and the sequence waits;
//    the next request is taken as soon as the last word sits in that register.
//  - Configuration channel (csr_valid / csr_ready / csr_index / csr_data) is
//    always ready; bit 0 of csr_data is used. Write it only while idle.
//  - After reset a clearing pass zeroes the store, one row per cycle;
//    req_stall stays high until it ends.
module sprite_line_evaluation #(
   parameter int ENTRY_COUNT = sle_pkg::ENTRY_COUNT_DEFAULT,
   parameter int LINE_SLOTS  = sle_pkg::LINE_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  sle_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output sle_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sle_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_data
);
   import sle_pkg::*;

   localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
   localparam int STORE_BYTES = ENTRY_COUNT * LANE_COUNT;
   localparam int KEEP_W      = $clog2(LINE_SLOTS + 1);
   localparam int SLOT_W      = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ENTRY_COUNT - 1);
   localparam logic [KEEP_W-1:0]  SLOT_LIMIT = KEEP_W'(LINE_SLOTS);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type           state_ff, state_in;
   logic [ENTRY_W-1:0]  ptr_ff, ptr_in;
   logic                issue_ff, issue_in;
   logic                eval_valid_ff, eval_valid_in;
   logic [ENTRY_W-1:0]  eval_entry_ff, eval_entry_in;
   logic [7:0]          line_ff, line_in;
   logic [KEEP_W-1:0]   kept_ff, kept_in;
   logic                zero_ff, zero_in;
   logic                over_ff, over_in;
   logic [KEEP_W-1:0]   emit_ptr_ff, emit_ptr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                tall_ff, tall_in;
   logic                table_sel_ff, table_sel_in;
   slot_type            slot_buf_ff [LINE_SLOTS];

   logic                slot_we;
   slot_type            slot_wdata;

   logic                   wr_en;
   logic [ENTRY_W-1:0]     wr_index;
   logic [LANE_COUNT-1:0]  wr_lanes;
   logic [ROW_BITS-1:0]    wr_data;
   logic                   rd_en;
   logic [ROW_BITS-1:0]    rd_data;

   logic [7:0]  ent_y, ent_tile, ent_attr, ent_x;
   logic [8:0]  diff;
   logic        hit;
   logic        out_free;
   logic        emit_last;
   slot_type    emit_rec;

   sle_store #(
      .ENTRY_COUNT(ENTRY_COUNT)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_index (wr_index),
      .wr_lanes (wr_lanes),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_index (ptr_ff),
      .rd_data  (rd_data)
   );

   // Split the returned row and test the line against it
   always_comb begin
      ent_y    = rd_data[0*LANE_BITS +: LANE_BITS];
      ent_tile = rd_data[1*LANE_BITS +: LANE_BITS];
      ent_attr = rd_data[2*LANE_BITS +: LANE_BITS];
      ent_x    = rd_data[3*LANE_BITS +: LANE_BITS];
      diff     = {1'b0, line_ff} - {1'b0, ent_y};
      hit      = ~diff[8] && (diff[7:4] == 4'd0) && (tall_ff || ~diff[3]);
      slot_wdata.plane_address     = plane_row_address(tall_ff, table_sel_ff, ent_tile,
                                                       ent_attr, diff[3:0]);
      slot_wdata.horizontal_pos    = ent_x;
      slot_wdata.palette_choice    = ent_attr[1:0];
      slot_wdata.behind_background = ent_attr[5];
      slot_wdata.mirror_horizontal = ent_attr[6];
   end

   // Result side helpers
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign emit_last = (KEEP_W'(emit_ptr_ff + 1'b1) == kept_ff);
   assign emit_rec  = slot_buf_ff[emit_ptr_ff[SLOT_W-1:0]];
   assign rd_en     = (state_ff == ST_SCAN) && issue_ff;

   // Configuration registers
   always_comb begin
      tall_in      = tall_ff;
      table_sel_in = table_sel_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TALL:      tall_in      = csr_data[0];
            CSR_TABLE_SEL: table_sel_in = csr_data[0];
            default: ;
         endcase
      end
   end

   // Sequencer: clear, accept, scan, emit
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      issue_in      = issue_ff;
      eval_valid_in = 1'b0;
      eval_entry_in = eval_entry_ff;
      line_in       = line_ff;
      kept_in       = kept_ff;
      zero_in       = zero_ff;
      over_in       = over_ff;
      emit_ptr_in   = emit_ptr_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_in        = rsp_ff;
      slot_we       = 1'b0;
      wr_en         = 1'b0;
      wr_index      = ptr_ff;
      wr_lanes      = '1;
      wr_data       = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_ENTRY) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_EVAL) begin
                  state_in = ST_SCAN;
                  line_in  = req_data.line_number;
                  ptr_in   = '0;
                  issue_in = 1'b1;
                  kept_in  = '0;
                  zero_in  = 1'b0;
                  over_in  = 1'b0;
               end else if (32'(req_data.store_address) < STORE_BYTES) begin
                  // store one byte in its lane; addresses past the store drop
                  wr_en    = 1'b1;
                  wr_index = ENTRY_W'(req_data.store_address[7:2]);
                  wr_lanes = LANE_COUNT'(1) << req_data.store_address[1:0];
                  wr_data  = {LANE_COUNT{req_data.store_data}};
               end
            end
         end

         ST_SCAN: begin
            // issue one row read per cycle
            if (issue_ff) begin
               eval_valid_in = 1'b1;
               eval_entry_in = ptr_ff;
               if (ptr_ff == LAST_ENTRY) begin
                  issue_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            // evaluate the row that came back
            if (eval_valid_ff) begin
               if (hit) begin
                  if (kept_ff < SLOT_LIMIT) begin
                     slot_we = 1'b1;
                     kept_in = kept_ff + 1'b1;
                     if (eval_entry_ff == '0) begin
                        zero_in = 1'b1;
                     end
                  end else begin
                     over_in = 1'b1;
                  end
               end
               if (eval_entry_ff == LAST_ENTRY) begin
                  state_in    = ST_EMIT;
                  emit_ptr_in = '0;
                  ptr_in      = '0;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (kept_ff == '0) begin
                  rsp_in             = '0;
                  rsp_in.last_result = 1'b1;
                  state_in           = ST_IDLE;
               end else begin
                  rsp_in.found             = 1'b1;
                  rsp_in.slot_index        = 3'(emit_ptr_ff);
                  rsp_in.plane_address     = emit_rec.plane_address;
                  rsp_in.horizontal_pos    = emit_rec.horizontal_pos;
                  rsp_in.palette_choice    = emit_rec.palette_choice;
                  rsp_in.behind_background = emit_rec.behind_background;
                  rsp_in.mirror_horizontal = emit_rec.mirror_horizontal;
                  rsp_in.zero_on_line      = zero_ff;
                  rsp_in.overflow_flag     = over_ff;
                  rsp_in.last_result       = emit_last;
                  if (emit_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     emit_ptr_in = emit_ptr_ff + 1'b1;
                  end
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, control and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ptr_ff        <= '0;
         issue_ff      <= 1'b0;
         eval_valid_ff <= 1'b0;
         kept_ff       <= '0;
         zero_ff       <= 1'b0;
         over_ff       <= 1'b0;
         emit_ptr_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         tall_ff       <= 1'b0;
         table_sel_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         issue_ff      <= issue_in;
         eval_valid_ff <= eval_valid_in;
         kept_ff       <= kept_in;
         zero_ff       <= zero_in;
         over_ff       <= over_in;
         emit_ptr_ff   <= emit_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
         tall_ff       <= tall_in;
         table_sel_ff  <= table_sel_in;
      end
      // payload needs no reset
      eval_entry_ff <= eval_entry_in;
      line_ff       <= line_in;
      rsp_ff        <= rsp_in;
      if (slot_we) begin
         slot_buf_ff[kept_ff[SLOT_W-1:0]] <= slot_wdata;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule
